// ----- design/gwpr_pkg.sv -----
`timescale 1ns / 1ps
package gwpr_pkg;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_PLAN  = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOPATH = 2'd1;
  localparam logic [1:0] ST_AT     = 2'd2;

  localparam logic [2:0] DIR_NONE = 3'd4;

  localparam int unsigned LW = 10;
  localparam logic [LW-1:0] LABEL_MAX = 10'd1023;

  typedef enum logic [2:0] {
    RES_WRITE,
    RES_PLAN_BAD,
    RES_PLAN_SAME,
    RES_PLAN_END,
    RES_STEP_NONE,
    RES_STEP_AT,
    RES_STEP_MOVE
  } res_e;

  typedef struct packed {
    logic ld;
    logic clr_init;
    logic clr_wr;
    logic clr_obs;
    logic seed;
    logic lvl_init;
    logic lvl_next;
    logic scan_rd;
    logic scan_adv;
    logic nb_init;
    logic nb_next;
    logic nb_wr;
    logic emit;
    res_e res;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       plan_bad;
    logic       same;
    logic       clr_last;
    logic       s_hit;
    logic       lvl_max;
    logic       added;
    logic       cell_match;
    logic       scan_last;
    logic       nb_ok;
    logic       nb_last;
    logic       lvl_zero;
    logic       lvl_one;
    logic       st_match;
  } sts_t;

endpackage

// ----- design/gwpr_ram.sv -----
`timescale 1ns / 1ps
module gwpr_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/gwpr_ctrl.sv -----
`timescale 1ns / 1ps
module gwpr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  gwpr_pkg::sts_t sts_i,
  output gwpr_pkg::cmd_t cmd_o,
  output logic           busy_o
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DEC   = 4'd2;
  localparam logic [3:0] S_PCLR  = 4'd3;
  localparam logic [3:0] S_PSEED = 4'd4;
  localparam logic [3:0] S_LVL   = 4'd5;
  localparam logic [3:0] S_SRD   = 4'd6;
  localparam logic [3:0] S_SCHK  = 4'd7;
  localparam logic [3:0] S_NRD   = 4'd8;
  localparam logic [3:0] S_NCHK  = 4'd9;
  localparam logic [3:0] S_LEND  = 4'd10;
  localparam logic [3:0] S_TRD   = 4'd11;
  localparam logic [3:0] S_TCHK  = 4'd12;

  logic [3:0] state_q, state_d;
  gwpr_pkg::cmd_t cmd;

  always_comb begin
    state_d = state_q;
    cmd = '0;
    cmd.res = gwpr_pkg::RES_WRITE;
    case (state_q)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        cmd.clr_obs = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd.ld = 1'b1;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        if (sts_i.op == gwpr_pkg::OP_PLAN) begin
          cmd.clr_init = 1'b1;
          state_d = S_PCLR;
        end else if (sts_i.op == gwpr_pkg::OP_STEP) begin
          if (sts_i.lvl_zero) begin
            cmd.emit = 1'b1;
            cmd.res = gwpr_pkg::RES_STEP_NONE;
            state_d = S_IDLE;
          end else if (sts_i.lvl_one) begin
            cmd.emit = 1'b1;
            cmd.res = gwpr_pkg::RES_STEP_AT;
            state_d = S_IDLE;
          end else begin
            cmd.nb_init = 1'b1;
            state_d = S_TRD;
          end
        end else begin
          cmd.emit = 1'b1;
          cmd.res = gwpr_pkg::RES_WRITE;
          state_d = S_IDLE;
        end
      end
      S_PCLR: begin
        cmd.clr_wr = 1'b1;
        if (sts_i.clr_last) state_d = S_PSEED;
      end
      S_PSEED: begin
        if (sts_i.plan_bad) begin
          cmd.emit = 1'b1;
          cmd.res = gwpr_pkg::RES_PLAN_BAD;
          state_d = S_IDLE;
        end else begin
          cmd.seed = 1'b1;
          if (sts_i.same) begin
            cmd.emit = 1'b1;
            cmd.res = gwpr_pkg::RES_PLAN_SAME;
            state_d = S_IDLE;
          end else begin
            cmd.lvl_init = 1'b1;
            state_d = S_LVL;
          end
        end
      end
      S_LVL: begin
        if (sts_i.s_hit || sts_i.lvl_max) begin
          cmd.emit = 1'b1;
          cmd.res = gwpr_pkg::RES_PLAN_END;
          state_d = S_IDLE;
        end else begin
          state_d = S_SRD;
        end
      end
      S_SRD: begin
        cmd.scan_rd = 1'b1;
        state_d = S_SCHK;
      end
      S_SCHK: begin
        if (sts_i.cell_match) begin
          cmd.nb_init = 1'b1;
          state_d = S_NRD;
        end else if (sts_i.scan_last) begin
          state_d = S_LEND;
        end else begin
          cmd.scan_adv = 1'b1;
          state_d = S_SRD;
        end
      end
      S_NRD, S_NCHK: begin
        if (state_q == S_NRD && sts_i.nb_ok) begin
          state_d = S_NCHK;
        end else begin
          cmd.nb_wr = (state_q == S_NCHK);
          if (!sts_i.nb_last) begin
            cmd.nb_next = 1'b1;
            state_d = S_NRD;
          end else if (sts_i.scan_last) begin
            state_d = S_LEND;
          end else begin
            cmd.scan_adv = 1'b1;
            state_d = S_SRD;
          end
        end
      end
      S_LEND: begin
        if (!sts_i.added) begin
          cmd.emit = 1'b1;
          cmd.res = gwpr_pkg::RES_PLAN_END;
          state_d = S_IDLE;
        end else begin
          cmd.lvl_next = 1'b1;
          state_d = S_LVL;
        end
      end
      S_TRD: begin
        if (sts_i.nb_ok) begin
          state_d = S_TCHK;
        end else if (sts_i.nb_last) begin
          cmd.emit = 1'b1;
          cmd.res = gwpr_pkg::RES_STEP_NONE;
          state_d = S_IDLE;
        end else begin
          cmd.nb_next = 1'b1;
        end
      end
      S_TCHK: begin
        if (sts_i.st_match) begin
          cmd.emit = 1'b1;
          cmd.res = gwpr_pkg::RES_STEP_MOVE;
          state_d = S_IDLE;
        end else if (sts_i.nb_last) begin
          cmd.emit = 1'b1;
          cmd.res = gwpr_pkg::RES_STEP_NONE;
          state_d = S_IDLE;
        end else begin
          cmd.nb_next = 1'b1;
          state_d = S_TRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o = cmd;
  assign busy_o = (state_q != S_IDLE);

endmodule

// ----- design/gwpr_dp.sv -----
`timescale 1ns / 1ps
module gwpr_dp #(
  parameter int GRID_ROWS = 16,
  parameter int GRID_COLS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  gwpr_pkg::cmd_t cmd_i,
  output gwpr_pkg::sts_t sts_o,
  input  logic [1:0]     operation_i,
  input  logic [3:0]     row_i,
  input  logic [4:0]     col_i,
  input  logic           blocked_i,
  input  logic [3:0]     target_row_i,
  input  logic [4:0]     target_col_i,
  output logic           done_o,
  output logic [1:0]     status_o,
  output logic [3:0]     pos_row_o,
  output logic [4:0]     pos_col_o,
  output logic [2:0]     direction_o,
  output logic [9:0]     distance_o
);

  localparam int CELLS = GRID_ROWS * GRID_COLS;
  localparam int AW = $clog2(CELLS);
  localparam int RW = ($clog2(GRID_ROWS) > 4) ? $clog2(GRID_ROWS) : 4;
  localparam int CW = ($clog2(GRID_COLS) > 5) ? $clog2(GRID_COLS) : 5;
  localparam int LW = gwpr_pkg::LW;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    return AW'(32'(r) * 32'(GRID_COLS) + 32'(c));
  endfunction

  logic [1:0]    op_q;
  logic [RW-1:0] row_q, tr_q, cur_r_q, sr_q;
  logic [CW-1:0] col_q, tc_q, cur_c_q, sc_q;
  logic          blk_q;
  logic [LW-1:0] lvl_q, wl_q, hitl_q;
  logic [1:0]    k_q;
  logic          added_q, hit_q;
  logic [AW-1:0] clr_q;

  logic          done_q;
  logic [1:0]    res_st_q;
  logic [RW-1:0] res_r_q;
  logic [CW-1:0] res_c_q;
  logic [2:0]    res_dir_q;
  logic [LW-1:0] res_lvl_q;

  logic [RW-1:0] base_r, nb_r;
  logic [CW-1:0] base_c, nb_c;
  logic          nb_ok, step_mode;
  logic [AW-1:0] nb_addr, s_addr, t_addr, cur_addr, scan_addr;
  logic [LW-1:0] lbl_rd;
  logic [0:0]    obs_rd;
  logic          start_in_grid, target_in_grid;
  logic          wave_wr;

  logic          lbl_we, obs_we;
  logic [AW-1:0] lbl_waddr, obs_waddr, lbl_raddr;
  logic [LW-1:0] lbl_wdata;
  logic [0:0]    obs_wdata;

  logic [RW-1:0] cur_r_d;
  logic [CW-1:0] cur_c_d;
  logic [LW-1:0] lvl_d;
  logic [1:0]    st_d;
  logic [2:0]    dir_d;

  assign step_mode = (op_q == gwpr_pkg::OP_STEP);
  assign base_r = step_mode ? cur_r_q : sr_q;
  assign base_c = step_mode ? cur_c_q : sc_q;

  // step moves stay on the grid, wave moves stay inside the border ring
  always_comb begin
    nb_r = base_r;
    nb_c = base_c;
    nb_ok = 1'b0;
    case (k_q)
      2'd0: begin
        nb_r = base_r - RW'(1);
        nb_ok = step_mode ? (base_r != '0) : (32'(base_r) >= 32'd2);
      end
      2'd1: begin
        nb_r = base_r + RW'(1);
        nb_ok = step_mode ? (32'(base_r) < 32'(GRID_ROWS - 1))
                          : (32'(base_r) <= 32'(GRID_ROWS - 3));
      end
      2'd2: begin
        nb_c = base_c - CW'(1);
        nb_ok = step_mode ? (base_c != '0) : (32'(base_c) >= 32'd2);
      end
      2'd3: begin
        nb_c = base_c + CW'(1);
        nb_ok = step_mode ? (32'(base_c) < 32'(GRID_COLS - 1))
                          : (32'(base_c) <= 32'(GRID_COLS - 3));
      end
      default: nb_ok = 1'b0;
    endcase
  end

  assign nb_addr   = cell_addr(nb_r, nb_c);
  assign s_addr    = cell_addr(row_q, col_q);
  assign t_addr    = cell_addr(tr_q, tc_q);
  assign cur_addr  = cell_addr(cur_r_q, cur_c_q);
  assign scan_addr = cell_addr(sr_q, sc_q);

  assign start_in_grid  = (32'(row_q) < 32'(GRID_ROWS)) && (32'(col_q) < 32'(GRID_COLS));
  assign target_in_grid = (32'(tr_q) < 32'(GRID_ROWS)) && (32'(tc_q) < 32'(GRID_COLS));

  // the start cell counts as free even if blocked
  assign wave_wr = cmd_i.nb_wr && (lbl_rd == '0) && ((obs_rd == 1'b0) || (nb_addr == s_addr));

  always_comb begin
    lbl_we = 1'b1;
    lbl_waddr = clr_q;
    lbl_wdata = '0;
    if (cmd_i.clr_wr) begin
      lbl_waddr = clr_q;
    end else if (cmd_i.seed) begin
      lbl_waddr = t_addr;
      lbl_wdata = LW'(1);
    end else if (wave_wr) begin
      lbl_waddr = nb_addr;
      lbl_wdata = wl_q + LW'(1);
    end else if (cmd_i.emit && cmd_i.res == gwpr_pkg::RES_STEP_MOVE) begin
      lbl_waddr = cur_addr;
    end else begin
      lbl_we = 1'b0;
    end
  end

  always_comb begin
    obs_we = 1'b0;
    obs_waddr = clr_q;
    obs_wdata = 1'b0;
    if (cmd_i.clr_wr && cmd_i.clr_obs) begin
      obs_we = 1'b1;
    end else if (cmd_i.emit && cmd_i.res == gwpr_pkg::RES_WRITE &&
                 op_q == gwpr_pkg::OP_WRITE && start_in_grid) begin
      obs_we = 1'b1;
      obs_waddr = s_addr;
      obs_wdata = blk_q;
    end
  end

  assign lbl_raddr = cmd_i.scan_rd ? scan_addr : nb_addr;

  gwpr_ram #(.WIDTH(LW), .DEPTH(CELLS)) u_label_ram (
    .clk_i  (clk_i),
    .we_i   (lbl_we),
    .waddr_i(lbl_waddr),
    .wdata_i(lbl_wdata),
    .raddr_i(lbl_raddr),
    .rdata_o(lbl_rd)
  );

  gwpr_ram #(.WIDTH(1), .DEPTH(CELLS)) u_obs_ram (
    .clk_i  (clk_i),
    .we_i   (obs_we),
    .waddr_i(obs_waddr),
    .wdata_i(obs_wdata),
    .raddr_i(nb_addr),
    .rdata_o(obs_rd)
  );

  // position and path label after the finishing operation
  always_comb begin
    cur_r_d = cur_r_q;
    cur_c_d = cur_c_q;
    lvl_d = lvl_q;
    st_d = gwpr_pkg::ST_OK;
    dir_d = gwpr_pkg::DIR_NONE;
    case (cmd_i.res)
      gwpr_pkg::RES_WRITE: st_d = gwpr_pkg::ST_OK;
      gwpr_pkg::RES_PLAN_BAD: begin
        lvl_d = '0;
        st_d = gwpr_pkg::ST_NOPATH;
      end
      gwpr_pkg::RES_PLAN_SAME: begin
        cur_r_d = row_q;
        cur_c_d = col_q;
        lvl_d = LW'(1);
        st_d = gwpr_pkg::ST_AT;
      end
      gwpr_pkg::RES_PLAN_END: begin
        cur_r_d = row_q;
        cur_c_d = col_q;
        lvl_d = hit_q ? hitl_q : '0;
        st_d = hit_q ? gwpr_pkg::ST_OK : gwpr_pkg::ST_NOPATH;
      end
      gwpr_pkg::RES_STEP_NONE: begin
        lvl_d = '0;
        st_d = gwpr_pkg::ST_NOPATH;
      end
      gwpr_pkg::RES_STEP_AT: st_d = gwpr_pkg::ST_AT;
      gwpr_pkg::RES_STEP_MOVE: begin
        cur_r_d = nb_r;
        cur_c_d = nb_c;
        lvl_d = lvl_q - LW'(1);
        dir_d = {1'b0, k_q};
      end
      default: st_d = gwpr_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_r_q <= '0;
      cur_c_q <= '0;
      lvl_q <= '0;
      clr_q <= '0;
      done_q <= 1'b0;
      op_q <= gwpr_pkg::OP_WRITE;
      k_q <= '0;
      wl_q <= '0;
      added_q <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
      if (cmd_i.ld) op_q <= operation_i;
      if (cmd_i.emit) begin
        cur_r_q <= cur_r_d;
        cur_c_q <= cur_c_d;
        lvl_q <= lvl_d;
      end
      if (cmd_i.clr_init) begin
        clr_q <= '0;
      end else if (cmd_i.clr_wr) begin
        clr_q <= (clr_q == AW'(CELLS - 1)) ? '0 : clr_q + AW'(1);
      end
      if (cmd_i.nb_init) begin
        k_q <= '0;
      end else if (cmd_i.nb_next) begin
        k_q <= k_q + 2'd1;
      end
      if (cmd_i.lvl_init) begin
        wl_q <= LW'(1);
        added_q <= 1'b0;
        hit_q <= 1'b0;
      end else if (cmd_i.lvl_next) begin
        wl_q <= wl_q + LW'(1);
        added_q <= 1'b0;
      end else if (wave_wr) begin
        added_q <= 1'b1;
        if (nb_addr == s_addr) hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld) begin
      row_q <= RW'(row_i);
      col_q <= CW'(col_i);
      blk_q <= blocked_i;
      tr_q <= RW'(target_row_i);
      tc_q <= CW'(target_col_i);
    end
    if (wave_wr && nb_addr == s_addr) hitl_q <= wl_q + LW'(1);
    if (cmd_i.lvl_init || cmd_i.lvl_next) begin
      sr_q <= RW'(1);
      sc_q <= CW'(1);
    end else if (cmd_i.scan_adv) begin
      if (32'(sc_q) == 32'(GRID_COLS - 2)) begin
        sc_q <= CW'(1);
        sr_q <= sr_q + RW'(1);
      end else begin
        sc_q <= sc_q + CW'(1);
      end
    end
    if (cmd_i.emit) begin
      res_st_q <= st_d;
      res_r_q <= cur_r_d;
      res_c_q <= cur_c_d;
      res_dir_q <= dir_d;
      res_lvl_q <= lvl_d;
    end
  end

  assign sts_o.op         = op_q;
  assign sts_o.plan_bad   = !(start_in_grid && target_in_grid);
  assign sts_o.same       = (row_q == tr_q) && (col_q == tc_q);
  assign sts_o.clr_last   = (clr_q == AW'(CELLS - 1));
  assign sts_o.s_hit      = hit_q;
  assign sts_o.lvl_max    = (wl_q == gwpr_pkg::LABEL_MAX);
  assign sts_o.added      = added_q;
  assign sts_o.cell_match = (lbl_rd == wl_q);
  assign sts_o.scan_last  = (32'(sr_q) == 32'(GRID_ROWS - 2)) &&
                            (32'(sc_q) == 32'(GRID_COLS - 2));
  assign sts_o.nb_ok      = nb_ok;
  assign sts_o.nb_last    = (k_q == 2'd3);
  assign sts_o.lvl_zero   = (lvl_q == '0);
  assign sts_o.lvl_one    = (lvl_q == LW'(1));
  assign sts_o.st_match   = (lbl_rd == lvl_q - LW'(1));

  assign done_o      = done_q;
  assign status_o    = res_st_q;
  assign pos_row_o   = res_r_q[3:0];
  assign pos_col_o   = res_c_q[4:0];
  assign direction_o = res_dir_q;
  assign distance_o  = res_lvl_q;

endmodule

// ----- design/grid_wave_path_router.sv -----
`timescale 1ns / 1ps
// channel   | handshake         | ports
// command   | start, busy       | operation_i row_i col_i blocked_i target_row_i target_col_i
// result    | done_o (strobe)   | status_o pos_row_o pos_col_o direction_o distance_o
//
// a command is taken when start is high and busy low; its result word follows
// on a one-cycle done_o strobe. a plan first clears the label memory, then
// scans the inner cells once per wave level and tries the four neighbours of
// each cell on that level, one at a time through the single label read port.
// after reset busy stays high while both memories are cleared.
// the receiver cannot stall: done_o is high for one cycle only; the result word holds until the next result.
module grid_wave_path_router #(
  parameter int GRID_ROWS = 16,
  parameter int GRID_COLS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] operation_i,
  input  logic [3:0] row_i,
  input  logic [4:0] col_i,
  input  logic       blocked_i,
  input  logic [3:0] target_row_i,
  input  logic [4:0] target_col_i,
  output logic       done_o,
  output logic [1:0] status_o,
  output logic [3:0] pos_row_o,
  output logic [4:0] pos_col_o,
  output logic [2:0] direction_o,
  output logic [9:0] distance_o
);

  gwpr_pkg::cmd_t cmd;
  gwpr_pkg::sts_t sts;

  gwpr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  gwpr_dp #(.GRID_ROWS(GRID_ROWS), .GRID_COLS(GRID_COLS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .operation_i (operation_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .blocked_i   (blocked_i),
    .target_row_i(target_row_i),
    .target_col_i(target_col_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .pos_row_o   (pos_row_o),
    .pos_col_o   (pos_col_o),
    .direction_o (direction_o),
    .distance_o  (distance_o)
  );

endmodule
